// ----- src/errc_pkg.sv -----
package errc_pkg;

  // input item opcodes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_CRC     = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef enum logic {
    PHASE_IDLE = 1'b0,
    PHASE_WAIT = 1'b1
  } phase_t;

  // configuration register indexes
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_READ_COMMAND   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd2;

  localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd128;
  localparam logic [7:0] READ_COMMAND_RESET   = 8'd16;
  localparam logic [7:0] TIMEOUT_TICKS_RESET  = 8'd4;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam int VALUE_BYTES = 4;

  // result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx;
    logic [31:0] value;
    logic        last;
  } result_t;

  // CRC-16, MSB first, one byte per call
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC after the reset address byte alone
  localparam logic [15:0] ADDR_CRC_RESET = crc16_byte(16'h0000, DEVICE_ADDRESS_RESET);

endpackage

// ----- src/encoder_read_response_checker_unit.sv -----
// Encoder read response checker: request bytes out, reply bytes in, CRC-16 check.
// An accepted item is held in the input register until the result queue has room;
// it then writes its results into the result queue register, which drives out_valid.
// Throughput: one byte or tick transaction per cycle while the result queue has room;
// a start transaction yields two results, so the single-result output port limits starts.
// Reset (rst, synchronous): idle, queue empty, registers at 128 / 16 / 4.
module encoder_read_response_checker_unit #(
  parameter int REPLY_BYTES = 7
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // input transactions
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  rx_byte,
  // result transactions
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic signed [31:0] count_value,
  output logic        last
);

  // bytes_seen counts 0..REPLY_BYTES-1; comparisons use one extra bit
  localparam int CW = $clog2(REPLY_BYTES);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] DATA_LIMIT  = SW'(REPLY_BYTES - 2);
  localparam logic [SW-1:0] REPLY_LIMIT = SW'(REPLY_BYTES);
  localparam logic [SW-1:0] VALUE_LIMIT = SW'(errc_pkg::VALUE_BYTES);
  localparam int CNTW = errc_pkg::OUT_AW + 1;
  localparam logic [CNTW-1:0] ROOM_LIMIT = CNTW'(errc_pkg::OUT_DEPTH - 2);

  // ---------------------------------------------------------------------------
  // Configuration registers. The address is kept alongside its CRC so that a
  // start only needs one more byte step (the command) through the CRC logic.
  // ---------------------------------------------------------------------------
  logic [7:0]  device_address;
  logic [7:0]  read_command;
  logic [7:0]  timeout_ticks;
  logic [15:0] addr_crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= errc_pkg::DEVICE_ADDRESS_RESET;
      read_command   <= errc_pkg::READ_COMMAND_RESET;
      timeout_ticks  <= errc_pkg::TIMEOUT_TICKS_RESET;
      addr_crc       <= errc_pkg::ADDR_CRC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        errc_pkg::REG_DEVICE_ADDRESS: begin
          device_address <= cfg_data;
          addr_crc       <= errc_pkg::crc16_byte(16'h0000, cfg_data);
        end
        errc_pkg::REG_READ_COMMAND:  read_command  <= cfg_data;
        errc_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;  // index beyond the register list is ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. An item waits here until the result queue has room for
  // the two results a start can produce.
  // ---------------------------------------------------------------------------
  logic       item_valid;
  logic [1:0] item_op;
  logic [7:0] item_byte;
  logic       fire;

  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_op   <= opcode;
      item_byte <= rx_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Transaction state
  // ---------------------------------------------------------------------------
  errc_pkg::phase_t phase, phase_next;
  logic [CW-1:0] bytes_seen, bytes_seen_next;
  logic [15:0]   running_crc, running_crc_next;
  logic [15:0]   received_crc, received_crc_next;
  logic [31:0]   value_shift, value_shift_next;
  logic [7:0]    elapsed_ticks, elapsed_ticks_next;

  // per-item terms
  logic [15:0]   crc_upd;
  logic [15:0]   start_crc;
  logic [SW-1:0] seen_ext, seen_inc;
  logic          is_data, is_value, is_done, crc_ok;
  logic [8:0]    tick_inc;
  logic          is_timeout;

  assign crc_upd    = errc_pkg::crc16_byte(running_crc, item_byte);
  assign start_crc  = errc_pkg::crc16_byte(addr_crc, read_command);
  assign seen_ext   = {1'b0, bytes_seen};
  assign seen_inc   = seen_ext + SW'(1);
  assign is_data    = seen_ext < DATA_LIMIT;
  assign is_value   = seen_ext < VALUE_LIMIT;
  assign is_done    = seen_inc >= REPLY_LIMIT;
  // the final reply byte is always the low CRC byte
  assign crc_ok     = {received_crc[7:0], item_byte} == running_crc;
  assign tick_inc   = {1'b0, elapsed_ticks} + 9'd1;
  assign is_timeout = tick_inc > {1'b0, timeout_ticks};

  // next state
  always_comb begin
    phase_next         = phase;
    bytes_seen_next    = bytes_seen;
    running_crc_next   = running_crc;
    received_crc_next  = received_crc;
    value_shift_next   = value_shift;
    elapsed_ticks_next = elapsed_ticks;
    if (fire) begin
      case (item_op)
        errc_pkg::OP_START: begin
          // a start while waiting drops the partial reply
          phase_next         = errc_pkg::PHASE_WAIT;
          bytes_seen_next    = '0;
          running_crc_next   = start_crc;
          received_crc_next  = '0;
          value_shift_next   = '0;
          elapsed_ticks_next = '0;
        end
        errc_pkg::OP_BYTE: begin
          if (phase == errc_pkg::PHASE_WAIT) begin
            if (is_data) begin
              running_crc_next = crc_upd;
              if (is_value) begin
                value_shift_next = {value_shift[23:0], item_byte};
              end
            end else begin
              received_crc_next = {received_crc[7:0], item_byte};
            end
            if (is_done) begin
              phase_next      = errc_pkg::PHASE_IDLE;
              bytes_seen_next = '0;
            end else begin
              bytes_seen_next = seen_inc[CW-1:0];
            end
          end
        end
        errc_pkg::OP_TICK: begin
          if (phase == errc_pkg::PHASE_WAIT) begin
            if (is_timeout) begin
              phase_next         = errc_pkg::PHASE_IDLE;
              bytes_seen_next    = '0;
              elapsed_ticks_next = tick_inc[8] ? 8'hFF : tick_inc[7:0];
            end else begin
              elapsed_ticks_next = tick_inc[7:0];
            end
          end
        end
        default: ;  // unused opcode: no effect
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= errc_pkg::PHASE_IDLE;
      bytes_seen    <= '0;
      running_crc   <= '0;
      received_crc  <= '0;
      value_shift   <= '0;
      elapsed_ticks <= '0;
    end else begin
      phase         <= phase_next;
      bytes_seen    <= bytes_seen_next;
      running_crc   <= running_crc_next;
      received_crc  <= received_crc_next;
      value_shift   <= value_shift_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

  // results produced by the item in the input register
  logic [1:0]        n_res;
  errc_pkg::result_t res0, res1;

  always_comb begin
    n_res = 2'd0;
    res0  = '0;
    res1  = '0;
    case (item_op)
      errc_pkg::OP_START: begin
        n_res      = 2'd2;
        res0.kind  = errc_pkg::KIND_TX;
        res0.tx    = device_address;
        res1.kind  = errc_pkg::KIND_TX;
        res1.tx    = read_command;
        res1.last  = 1'b1;
      end
      errc_pkg::OP_BYTE: begin
        if (phase == errc_pkg::PHASE_WAIT && is_done) begin
          n_res     = 2'd1;
          res0.last = 1'b1;
          if (crc_ok) begin
            res0.kind  = errc_pkg::KIND_GOOD;
            res0.value = value_shift;
          end else begin
            res0.kind = errc_pkg::KIND_CRC;
          end
        end
      end
      errc_pkg::OP_TICK: begin
        if (phase == errc_pkg::PHASE_WAIT && is_timeout) begin
          n_res     = 2'd1;
          res0.kind = errc_pkg::KIND_TIMEOUT;
          res0.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result queue: small register FIFO, up to two pushes and one pop per cycle.
  // ---------------------------------------------------------------------------
  errc_pkg::result_t queue [errc_pkg::OUT_DEPTH];
  logic [errc_pkg::OUT_AW-1:0] wr_ptr, rd_ptr;
  logic [CNTW-1:0]             q_count, q_after_pop;
  logic                        pop;
  logic [errc_pkg::OUT_AW-1:0] wr_ptr_1;
  logic [1:0]                  n_push;

  assign pop         = out_valid && out_ready;
  assign q_after_pop = q_count - CNTW'(pop);
  assign fire        = item_valid && (q_after_pop <= ROOM_LIMIT);
  assign n_push      = fire ? n_res : 2'd0;
  assign wr_ptr_1    = wr_ptr + errc_pkg::OUT_AW'(1);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (n_push == 2'd2) begin
      queue[wr_ptr_1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + errc_pkg::OUT_AW'(n_push);
      rd_ptr  <= rd_ptr + errc_pkg::OUT_AW'(pop);
      q_count <= q_after_pop + CNTW'(n_push);
    end
  end

  assign out_valid   = q_count != '0;
  assign kind        = queue[rd_ptr].kind;
  assign tx_byte     = queue[rd_ptr].tx;
  assign count_value = queue[rd_ptr].value;
  assign last        = queue[rd_ptr].last;

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Run parameters
  // ---------------------------------------------------------------------------
  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 12;
  localparam int REPLY_LEN       = 7;              // reply bytes: data + 2 CRC
  localparam int DATA_LEN        = REPLY_LEN - 2;
  localparam int GAP_MAX         = 10;             // longest per-transaction idle
  localparam int HOLD_OFF_CYCLES = 300;            // long receiver stall
  localparam int SETTLE_CYCLES   = 6;              // > accept-to-result latency
  localparam int WATCHDOG_LIMIT  = 3000;           // cycles with no transaction
  localparam int RANDOM_ITEMS    = 1250;
  localparam int PHASE_ITEMS     = 100;            // items between reg changes

  // opcode 3 is not decoded; register index 3 is not mapped
  localparam logic [1:0] OP_RESERVED  = 2'd3;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } link_item_t;

  typedef struct packed {
    errc_pkg::kind_t kind;
    logic [7:0]      tx;
    logic [31:0]     count;
    logic            last;
  } link_result_t;

  typedef enum int {
    REPLY_CLEAN,
    REPLY_CORRUPT,
    REPLY_TIMEOUT,
    REPLY_ABANDON
  } reply_style_t;

  // ---------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [7:0]        cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        opcode = '0;
  logic [7:0]        rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        kind;
  logic [7:0]        tx_byte;
  logic signed [31:0] count_value;
  logic              last;

  always #(CLK_PERIOD / 2) clk = ~clk;

  encoder_read_response_checker_unit #(
    .REPLY_BYTES(REPLY_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .tx_byte(tx_byte),
    .count_value(count_value),
    .last(last)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  link_item_t   send_queue[$];        // input transactions not yet offered
  link_result_t awaited_results[$];   // predicted results, oldest first

  int error_count = 0;
  int counted_items = 0;              // stimulus items toward the random quota
  int accepted_items = 0;
  int settings_written = 0;
  int seen_tx = 0, seen_good = 0, seen_crc = 0, seen_timeout = 0;

  int send_gap_max = GAP_MAX;         // per-phase idle ceilings, 0 = back to back
  int recv_gap_max = GAP_MAX;
  int hold_orders = 0;                // bumped by the sequencer to request a stall

  // ---------------------------------------------------------------------------
  // Link model: register copies and reply-tracking state
  // ---------------------------------------------------------------------------
  logic [7:0]       addr_setting;
  logic [7:0]       cmd_setting;
  logic [7:0]       timeout_setting;
  errc_pkg::phase_t link_phase;
  int               reply_index;
  logic [15:0]      crc_calc;         // CRC over address, command, data
  logic [15:0]      crc_wire;         // CRC bytes as received
  logic [31:0]      value_acc;
  logic [7:0]       ticks_elapsed;

  // CRC-16 0x1021, fed one data bit at a time, MSB first
  function automatic logic [15:0] crc_update(logic [15:0] acc, logic [7:0] b);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb  = acc[15] ^ b[k];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ errc_pkg::CRC_POLY;
      end
    end
    return acc;
  endfunction

  // Byte idx of a well-formed reply: data bytes, then CRC high, CRC low
  function automatic logic [7:0] reply_byte(logic [7:0] a, logic [7:0] c,
                                            logic [8*DATA_LEN-1:0] data, int idx);
    logic [15:0] crc;
    if (idx < DATA_LEN) begin
      return data[8*DATA_LEN-1-8*idx -: 8];
    end
    crc = crc_update(crc_update(16'h0000, a), c);
    for (int k = 0; k < DATA_LEN; k++) begin
      crc = crc_update(crc, data[8*DATA_LEN-1-8*k -: 8]);
    end
    return (idx == DATA_LEN) ? crc[15:8] : crc[7:0];
  endfunction

  // Advance the model by one accepted transaction, queue what it should emit
  task automatic link_model_step(input logic [1:0] op, input logic [7:0] b);
    logic [8:0] next_ticks;
    case (op)
      errc_pkg::OP_START: begin
        // restart is legal mid-reply: partial reply is dropped
        awaited_results.push_back(
          link_result_t'{errc_pkg::KIND_TX, addr_setting, 32'd0, 1'b0});
        awaited_results.push_back(
          link_result_t'{errc_pkg::KIND_TX, cmd_setting, 32'd0, 1'b1});
        crc_calc      = crc_update(crc_update(16'h0000, addr_setting), cmd_setting);
        crc_wire      = '0;
        value_acc     = '0;
        reply_index   = 0;
        ticks_elapsed = '0;
        link_phase    = errc_pkg::PHASE_WAIT;
      end
      errc_pkg::OP_BYTE: begin
        if (link_phase == errc_pkg::PHASE_WAIT) begin
          if (reply_index < DATA_LEN) begin
            crc_calc = crc_update(crc_calc, b);
            if (reply_index < errc_pkg::VALUE_BYTES) begin
              value_acc = {value_acc[23:0], b};
            end
          end else begin
            crc_wire = {crc_wire[7:0], b};
          end
          reply_index++;
          if (reply_index >= REPLY_LEN) begin
            link_phase  = errc_pkg::PHASE_IDLE;
            reply_index = 0;
            if (crc_wire == crc_calc) begin
              awaited_results.push_back(
                link_result_t'{errc_pkg::KIND_GOOD, 8'd0, value_acc, 1'b1});
            end else begin
              awaited_results.push_back(
                link_result_t'{errc_pkg::KIND_CRC, 8'd0, 32'd0, 1'b1});
            end
          end
        end
      end
      errc_pkg::OP_TICK: begin
        if (link_phase == errc_pkg::PHASE_WAIT) begin
          // compare uses count + 1 unclipped, so limit 255 still expires
          next_ticks = {1'b0, ticks_elapsed} + 9'd1;
          if (next_ticks > {1'b0, timeout_setting}) begin
            link_phase    = errc_pkg::PHASE_IDLE;
            reply_index   = 0;
            ticks_elapsed = next_ticks[8] ? 8'hFF : next_ticks[7:0];
            awaited_results.push_back(
              link_result_t'{errc_pkg::KIND_TIMEOUT, 8'd0, 32'd0, 1'b1});
          end else begin
            ticks_elapsed = next_ticks[7:0];
          end
        end
      end
      default: ;  // reserved opcode, no effect
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued transactions with a random gap after each accept
  // ---------------------------------------------------------------------------
  int         send_wait = 0;
  link_item_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        link_model_step(opcode, rx_byte);
        accepted_items++;
        send_wait = $urandom_range(0, send_gap_max);
      end
      // payload only moves once the current transaction is gone
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (send_queue.size() != 0) begin
          next_item = send_queue.pop_front();
          in_valid <= 1'b1;
          opcode   <= next_item.op;
          rx_byte  <= next_item.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every result, throttles out_ready
  // ---------------------------------------------------------------------------
  int           recv_wait = 0;
  int           hold_left = 0;
  int           hold_served = 0;
  link_result_t want;

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display({"%0t: unexpected result, expected none, ",
                    "actual kind %0d tx 0x%0h value 0x%0h last %0b"},
                   $time, kind, tx_byte, count_value, last);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("tx_byte", 32'(want.tx), 32'(tx_byte));
          check_field("count_value", want.count, count_value);
          check_field("last", 32'(want.last), 32'(last));
          case (want.kind)
            errc_pkg::KIND_TX:   seen_tx++;
            errc_pkg::KIND_GOOD: seen_good++;
            errc_pkg::KIND_CRC:  seen_crc++;
            default:             seen_timeout++;
          endcase
        end
        recv_wait = $urandom_range(0, recv_gap_max);
      end
      // a new stall order starts a long hold-off counted here
      if (hold_served != hold_orders) begin
        hold_served = hold_orders;
        hold_left   = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run when neither channel moves for too long
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results still awaited",
               $time, quiet_cycles, awaited_results.size());
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic [1:0] op, input logic [7:0] b, input int counts);
    send_queue.push_back(link_item_t'{op, b});
    counted_items += counts;
  endtask

  // registers only change with nothing in flight, so the model updates at once
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      errc_pkg::REG_DEVICE_ADDRESS: addr_setting = val;
      errc_pkg::REG_READ_COMMAND:   cmd_setting = val;
      errc_pkg::REG_TIMEOUT_TICKS:  timeout_setting = val;
      default: ;  // unmapped index is dropped by the block too
    endcase
    settings_written++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender pause: everything offered, accepted and answered, then let
  // result-free transactions clear the pipeline
  task automatic wait_idle();
    @(negedge clk);
    while (send_queue.size() != 0 || in_valid || awaited_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // byte extremes (including sign boundaries) or a random byte
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one read: start, reply bytes with ticks sprinkled under the limit; a timeout adds ticks past it
  task automatic queue_transaction(input reply_style_t style);
    logic [8*DATA_LEN-1:0] data;
    logic [7:0]            b;
    logic [7:0]            flip_mask;
    int                    n_bytes;
    int                    bad_idx;
    int                    ticks_used;
    data[31:0]             = $urandom;
    data[8*DATA_LEN-1:32]  = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      data[8*DATA_LEN-1 -: 8] = pick_byte();
    end
    n_bytes = (style == REPLY_TIMEOUT || style == REPLY_ABANDON) ?
              $urandom_range(0, REPLY_LEN - 1) : REPLY_LEN;
    bad_idx    = $urandom_range(0, REPLY_LEN - 1);
    flip_mask  = 8'h01 << $urandom_range(0, 7);
    ticks_used = 0;
    push_item(errc_pkg::OP_START, 8'($urandom_range(0, 255)), 1);
    for (int i = 0; i < n_bytes; i++) begin
      if (ticks_used < int'(timeout_setting) && $urandom_range(0, 3) == 0) begin
        push_item(errc_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1);
        ticks_used++;
      end
      b = reply_byte(addr_setting, cmd_setting, data, i);
      if (style == REPLY_CORRUPT && i == bad_idx) begin
        b ^= flip_mask;
      end
      push_item(errc_pkg::OP_BYTE, b, 1);
    end
    if (style == REPLY_TIMEOUT) begin
      repeat (int'(timeout_setting) - ticks_used + 1) begin
        push_item(errc_pkg::OP_TICK, 8'($urandom_range(0, 255)), 1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    logic [8*DATA_LEN-1:0] dir_data;
    logic [7:0]            held_addr;
    logic [7:0]            held_cmd;
    int                    phase_no;
    int                    phase_base;
    int                    draw;
    logic [7:0]            limit;

    addr_setting    = errc_pkg::DEVICE_ADDRESS_RESET;
    cmd_setting     = errc_pkg::READ_COMMAND_RESET;
    timeout_setting = errc_pkg::TIMEOUT_TICKS_RESET;
    link_phase      = errc_pkg::PHASE_IDLE;
    reply_index     = 0;
    crc_calc        = '0;
    crc_wire        = '0;
    value_acc       = '0;
    ticks_elapsed   = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // --- directed: reset register values ---
    // tick and byte while idle are dropped
    push_item(errc_pkg::OP_TICK, 8'hFF, 0);
    push_item(errc_pkg::OP_BYTE, 8'hFF, 0);
    // largest positive count, bad CRC low byte
    dir_data = 40'h7FFFFFFF00;
    push_item(errc_pkg::OP_START, 8'h00, 0);
    for (int i = 0; i < REPLY_LEN; i++) begin
      push_item(errc_pkg::OP_BYTE, reply_byte(addr_setting, cmd_setting, dir_data, i) ^
                                   ((i == REPLY_LEN - 1) ? 8'h01 : 8'h00), 0);
    end
    // reserved opcode mid-reply, then restart; most negative count, good CRC
    push_item(errc_pkg::OP_START, 8'h00, 0);
    push_item(errc_pkg::OP_BYTE, 8'h00, 0);
    push_item(OP_RESERVED, 8'hA5, 0);
    push_item(errc_pkg::OP_START, 8'h00, 0);
    dir_data = 40'h80000000FF;
    for (int i = 0; i < REPLY_LEN; i++) begin
      push_item(errc_pkg::OP_BYTE, reply_byte(addr_setting, cmd_setting, dir_data, i), 0);
    end
    // default limit of 4 expires on the fifth tick
    push_item(errc_pkg::OP_START, 8'h00, 0);
    repeat (int'(timeout_setting) + 1) push_item(errc_pkg::OP_TICK, 8'h00, 0);

    // zero limit: first tick expires; unmapped index write is ignored
    wait_idle();
    write_reg(REG_UNMAPPED, 8'hFF);
    write_reg(errc_pkg::REG_TIMEOUT_TICKS, 8'h00);
    push_item(errc_pkg::OP_START, 8'h00, 0);
    push_item(errc_pkg::OP_TICK, 8'h00, 0);

    // registers rewritten while a reply is pending: address and command
    // were latched at start, the new limit applies to later ticks
    wait_idle();
    write_reg(errc_pkg::REG_TIMEOUT_TICKS, 8'd3);
    held_addr = addr_setting;
    held_cmd  = cmd_setting;
    dir_data  = {8'($urandom_range(0, 255)), $urandom};
    push_item(errc_pkg::OP_START, 8'h00, 0);
    push_item(errc_pkg::OP_BYTE, reply_byte(held_addr, held_cmd, dir_data, 0), 0);
    push_item(errc_pkg::OP_BYTE, reply_byte(held_addr, held_cmd, dir_data, 1), 0);
    push_item(errc_pkg::OP_TICK, 8'h00, 0);
    wait_idle();
    write_reg(errc_pkg::REG_DEVICE_ADDRESS, 8'h00);
    write_reg(errc_pkg::REG_READ_COMMAND, 8'hFF);
    write_reg(errc_pkg::REG_TIMEOUT_TICKS, 8'd2);
    for (int i = 2; i < REPLY_LEN; i++) begin
      push_item(errc_pkg::OP_BYTE, reply_byte(held_addr, held_cmd, dir_data, i), 0);
    end
    push_item(errc_pkg::OP_START, 8'h00, 0);
    repeat (3) push_item(errc_pkg::OP_TICK, 8'h00, 0);

    // --- random phases, registers re-drawn between them ---
    counted_items = 0;
    phase_no      = 0;
    while (counted_items < RANDOM_ITEMS) begin
      wait_idle();
      write_reg(errc_pkg::REG_DEVICE_ADDRESS, pick_byte());
      write_reg(errc_pkg::REG_READ_COMMAND, pick_byte());
      case ($urandom_range(0, 9))
        0:       limit = 8'd0;
        1:       limit = 8'd255;
        default: limit = 8'($urandom_range(1, 6));
      endcase
      if (phase_no == 1) begin
        limit = 8'd255;   // full-range limit, forced to expire below
      end
      write_reg(errc_pkg::REG_TIMEOUT_TICKS, limit);
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      if (phase_no == 2) begin
        // receiver stalls long while the sender streams: block backs up
        hold_orders++;
        send_gap_max = 0;
      end
      phase_base = counted_items;
      while (counted_items - phase_base < PHASE_ITEMS) begin
        draw = $urandom_range(0, 19);
        if (phase_no == 1 && counted_items == phase_base) begin
          queue_transaction(REPLY_TIMEOUT);
        end else if (draw < 13) begin
          queue_transaction(REPLY_CLEAN);
        end else if (draw < 16) begin
          queue_transaction(REPLY_CORRUPT);
        end else if (draw < 18) begin
          // keep long tick runs to the one forced case
          queue_transaction((timeout_setting > 8'd16) ? REPLY_ABANDON : REPLY_TIMEOUT);
        end else if (draw == 18) begin
          queue_transaction(REPLY_ABANDON);
        end else begin
          // noise: any opcode, any byte, in any protocol state
          repeat ($urandom_range(1, 4)) begin
            push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 0);
          end
        end
      end
      phase_no++;
    end

    wait_idle();
    $display("covered %0d input transactions in %0d register phases, %0d register writes",
             accepted_items, phase_no, settings_written);
    $display("results checked: %0d request bytes, %0d good counts, %0d CRC errors, %0d timeouts",
             seen_tx, seen_good, seen_crc, seen_timeout);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
